[hdl/cht_pkg.sv]
// ============================================================================
// cht_pkg
// Types and codes shared by the checked handle table: request and response
// payloads, opcodes, status codes and configuration register indexes.
// ============================================================================
package cht_pkg;

    localparam int HANDLE_BITS    = 32;
    localparam int DATA_BITS      = 32;
    localparam int BASE_BITS      = 8;
    localparam int HIDX_BITS      = 23;
    localparam int COUNT_CFG_BITS = 9;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 9;
    localparam int GROUP_BITS     = 16;
    localparam int GROUP_OFF_BITS = 4;

    localparam logic [2:0] OP_CREATE     = 3'd0;
    localparam logic [2:0] OP_LOOKUP     = 3'd1;
    localparam logic [2:0] OP_DELETE     = 3'd2;
    localparam logic [2:0] OP_ITER_START = 3'd3;
    localparam logic [2:0] OP_ITER_NEXT  = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NULL  = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_BAD   = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_FAULT = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_BASE     = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_SLOTS = 1'd1;

    typedef struct packed {
        logic [2:0]             opcode;
        logic [HANDLE_BITS-1:0] handle;
        logic [DATA_BITS-1:0]   value;
    } req_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [HANDLE_BITS-1:0] handle_out;
        logic [DATA_BITS-1:0]   value_out;
    } rsp_t;

endpackage

[hdl/checked_handle_table_core.sv]
// ============================================================================
// checked_handle_table_core
// Handle table with salted handles: create, lookup, delete and iteration over
// a slot memory with a used-bit vector and a two-level free/used slot search.
// ============================================================================
// One request is worked at a time. Lookup, delete, iterate start and unknown
// opcodes present a valid response after the handle check and the slot
// memory read; create and iterate next first pass through the used-bit
// search (candidate mask, group select, slot select) followed by the
// memory access. A new request is accepted the cycle after the previous
// response is loaded into the output register, even while it waits to be
// taken; a response left waiting stalls the next request in its last stage.
// The used bits clear at reset; no clearing pass is needed.
module checked_handle_table_core #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  cht_pkg::req_t                         req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output cht_pkg::rsp_t                         rsp,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cht_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [cht_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int SW        = (VALUE_BITS < cht_pkg::DATA_BITS) ? VALUE_BITS
                                                                 : cht_pkg::DATA_BITS;
    localparam int IW        = $clog2(SLOTS);
    localparam int CW        = $clog2(SLOTS + 1);
    localparam int GW        = cht_pkg::GROUP_BITS;
    localparam int OW        = cht_pkg::GROUP_OFF_BITS;
    localparam int NG        = (SLOTS + GW - 1) / GW;
    localparam int GIW       = (NG > 1) ? $clog2(NG) : 1;
    localparam int PW        = NG * GW;
    localparam int RESET_POS = (SLOTS < 256) ? SLOTS : 256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_GROUP,
        S_PICK,
        S_DONE
    } state_t;

    state_t                         state_reg;
    cht_pkg::req_t                  req_reg;
    logic [PW-1:0]                  cand_reg;
    logic [GIW-1:0]                 grp_reg;
    logic [GW-1:0]                  slice_reg;
    logic                           grp_hit_reg;
    logic [IW-1:0]                  idx_reg;
    logic                           hit_reg;
    logic                           fault_reg;
    logic [SW-1:0]                  rd_data_reg;
    cht_pkg::rsp_t                  rsp_reg;
    cht_pkg::rsp_t                  rsp_next;
    logic                           rsp_valid_reg;
    logic [CW-1:0]                  iter_pos_reg;
    logic                           iter_adv_reg;
    logic [SLOTS-1:0]               slot_used_reg;
    logic [cht_pkg::BASE_BITS-1:0]  map_base_reg;
    logic [cht_pkg::COUNT_CFG_BITS-1:0] active_slots_reg;

    logic [SW-1:0]                  slot_value [SLOTS];

    logic [CW-1:0]                  live_n;
    logic [CW-1:0]                  iter_start;
    logic [cht_pkg::HIDX_BITS-1:0]  h_idx;
    logic [IW-1:0]                  h_slot;
    logic                           h_ok;
    logic [SW-1:0]                  val_m;
    logic                           val_zero;
    logic [PW-1:0]                  cand;
    logic                           grp_hit;
    logic [GIW-1:0]                 grp_sel;
    logic [GW-1:0]                  slice_sel;
    logic [OW-1:0]                  off_sel;
    logic [IW-1:0]                  pick_idx;
    logic                           rd_en;
    logic [IW-1:0]                  rd_addr;
    logic                           wr_en;
    logic                           done_fire;

    function automatic logic [cht_pkg::HANDLE_BITS-1:0] make_handle(
        input logic [IW-1:0]                 idx,
        input logic [cht_pkg::BASE_BITS-1:0] base
    );
        make_handle = {cht_pkg::HIDX_BITS'(idx), base, 1'b1};
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign live_n = (32'(active_slots_reg) > 32'(SLOTS)) ? CW'(SLOTS)
                                                         : CW'(active_slots_reg);
    assign iter_start = iter_pos_reg + CW'(iter_adv_reg);

    assign h_idx  = req_reg.handle[cht_pkg::HANDLE_BITS-1:cht_pkg::BASE_BITS+1];
    assign h_slot = req_reg.handle[cht_pkg::BASE_BITS+1 +: IW];
    assign h_ok   = req_reg.handle[0]
                 && (req_reg.handle[cht_pkg::BASE_BITS:1] == map_base_reg)
                 && (32'(h_idx) < 32'(live_n));

    assign val_m    = req_reg.value[SW-1:0];
    assign val_zero = (val_m == '0);

    // candidate mask: free slots for create, used slots at or past the cursor
    always_comb
    begin
        cand = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (32'(j) < 32'(live_n))
            begin
                if (req_reg.opcode == cht_pkg::OP_CREATE)
                    cand[j] = !slot_used_reg[j];
                else
                    cand[j] = slot_used_reg[j] && (32'(j) >= 32'(iter_start));
            end
        end
    end

    always_comb
    begin
        grp_hit   = 1'b0;
        grp_sel   = '0;
        slice_sel = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (|cand_reg[g*GW +: GW])
            begin
                grp_hit   = 1'b1;
                grp_sel   = GIW'(g);
                slice_sel = cand_reg[g*GW +: GW];
            end
        end
    end

    always_comb
    begin
        off_sel = '0;
        for (int k = GW - 1; k >= 0; k--)
        begin
            if (slice_reg[k])
                off_sel = OW'(k);
        end
    end

    always_comb
    begin
        rsp_next.status     = cht_pkg::ST_BAD;
        rsp_next.handle_out = '0;
        rsp_next.value_out  = '0;
        case (req_reg.opcode)
            cht_pkg::OP_CREATE:
            begin
                if (val_zero)
                    rsp_next.status = cht_pkg::ST_NULL;
                else if (grp_hit_reg)
                begin
                    rsp_next.status     = cht_pkg::ST_OK;
                    rsp_next.handle_out = make_handle(idx_reg, map_base_reg);
                end
                else
                    rsp_next.status = cht_pkg::ST_FULL;
            end
            cht_pkg::OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    rsp_next.status    = cht_pkg::ST_OK;
                    rsp_next.value_out = cht_pkg::DATA_BITS'(rd_data_reg);
                end
            end
            cht_pkg::OP_DELETE:
            begin
                if (hit_reg)
                    rsp_next.status = cht_pkg::ST_OK;
            end
            cht_pkg::OP_ITER_START:
                rsp_next.status = cht_pkg::ST_OK;
            cht_pkg::OP_ITER_NEXT:
            begin
                if (fault_reg)
                    rsp_next.status = cht_pkg::ST_FAULT;
                else if (grp_hit_reg)
                begin
                    rsp_next.status     = cht_pkg::ST_OK;
                    rsp_next.handle_out = make_handle(idx_reg, map_base_reg);
                    rsp_next.value_out  = cht_pkg::DATA_BITS'(rd_data_reg);
                end
                else
                    rsp_next.status = cht_pkg::ST_END;
            end
            default:
                rsp_next.status = cht_pkg::ST_BAD;
        endcase
    end

    assign pick_idx  = IW'({grp_reg, off_sel});
    assign rd_en     = ((state_reg == S_CAND) && (req_reg.opcode == cht_pkg::OP_LOOKUP))
                    || (state_reg == S_PICK);
    assign rd_addr   = (state_reg == S_PICK) ? pick_idx : h_slot;
    assign done_fire = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);
    assign wr_en     = done_fire && (req_reg.opcode == cht_pkg::OP_CREATE)
                    && !val_zero && grp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_value[idx_reg] <= val_m;
        if (rd_en)
            rd_data_reg <= slot_value[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_base_reg     <= 8'd1;
            active_slots_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cht_pkg::CFG_MAP_BASE:
                    map_base_reg <= cfg_data[cht_pkg::BASE_BITS-1:0];
                cht_pkg::CFG_ACTIVE_SLOTS:
                    active_slots_reg <= cfg_data;
                default:
                    active_slots_reg <= active_slots_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            iter_pos_reg  <= CW'(RESET_POS);
            iter_adv_reg  <= 1'b0;
            slot_used_reg <= '0;
        end
        else
        begin
            if (done_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        state_reg <= S_CAND;
                    end
                end
                S_CAND:
                begin
                    cand_reg  <= cand;
                    hit_reg   <= h_ok && slot_used_reg[h_slot];
                    fault_reg <= (iter_pos_reg >= live_n);
                    if ((req_reg.opcode == cht_pkg::OP_CREATE)
                        || (req_reg.opcode == cht_pkg::OP_ITER_NEXT))
                        state_reg <= S_GROUP;
                    else
                        state_reg <= S_DONE;
                end
                S_GROUP:
                begin
                    grp_hit_reg <= grp_hit;
                    grp_reg     <= grp_sel;
                    slice_reg   <= slice_sel;
                    state_reg   <= S_PICK;
                end
                S_PICK:
                begin
                    idx_reg   <= pick_idx;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        rsp_reg   <= rsp_next;
                        state_reg <= S_IDLE;
                        case (req_reg.opcode)
                            cht_pkg::OP_CREATE:
                            begin
                                if (!val_zero && grp_hit_reg)
                                    slot_used_reg[idx_reg] <= 1'b1;
                            end
                            cht_pkg::OP_DELETE:
                            begin
                                if (hit_reg)
                                    slot_used_reg[h_slot] <= 1'b0;
                            end
                            cht_pkg::OP_ITER_START:
                            begin
                                iter_pos_reg <= '0;
                                iter_adv_reg <= 1'b0;
                            end
                            cht_pkg::OP_ITER_NEXT:
                            begin
                                if (!fault_reg)
                                begin
                                    if (grp_hit_reg)
                                    begin
                                        iter_pos_reg <= CW'(idx_reg);
                                        iter_adv_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        iter_pos_reg <= live_n;
                                        iter_adv_reg <= 1'b0;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_loads_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire |=> rsp_valid_reg)
        else $error("completed request did not raise response valid");

    a_create_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> slot_used_reg[$past(idx_reg)])
        else $error("created slot not marked used");

    a_delete_clears_used: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire && (req_reg.opcode == cht_pkg::OP_DELETE) && hit_reg
        |=> !slot_used_reg[$past(h_slot)])
        else $error("deleted slot still marked used");

endmodule
